FILE: src/cpp_pkg.sv
package cpp_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int FRAC_BITS    = 16;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int N_W    = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W  = 13;
    localparam int T_W    = FRAC_BITS + 1;
    localparam int NUM_W  = 32 + FRAC_BITS;

    localparam logic [63:0] EPS_SQ =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
    localparam logic [T_W-1:0] ONE_T  = T_W'(1) << FRAC_BITS;
    localparam logic [T_W-1:0] HALF_T = T_W'(1) << (FRAC_BITS - 1);
    localparam logic [31:0]    NO_CENTER = 32'h7FFF_FFFF;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [31:0] word_t;
    typedef word_t [2:0] vec_t;

    typedef struct packed {
        logic starts;
        vec_t cen;
        vec_t tan;
        vec_t pos;
    } vertex_t;

    localparam int VTX_W = $bits(vertex_t);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SEG,
        ST_DIFF,
        ST_MLD,
        ST_MLD_W,
        ST_TDEC,
        ST_DIV,
        ST_MLP,
        ST_MLP_W,
        ST_EDIFF,
        ST_MDST,
        ST_MDST_W,
        ST_CMP,
        ST_NORM,
        ST_MNRM,
        ST_MNRM_W,
        ST_SQ0,
        ST_SQRT,
        ST_DCHK,
        ST_DINIT,
        ST_DDIV,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        M_NONE,
        M_LEN,
        M_DOT,
        M_LP,
        M_LT,
        M_DST,
        M_NRM
    } mop_t;

    typedef struct packed {
        logic [N_W-1:0]      i;
        logic [N_W-1:0]      n;
        logic [5:0]          k;
        logic [1:0]          j;
        vec_t                p;
        vertex_t             a;
        vertex_t             b;
        vec_t                ab;
        vec_t                ap;
        vec_t                dt;
        logic [63:0]         len_acc;
        logic signed [65:0]  dot_acc;
        logic [T_W-1:0]      t;
        logic [63:0]         r;
        vec_t                q;
        vec_t                tl;
        vec_t                e;
        logic [63:0]         dist_acc;
        logic                have;
        logic                found;
        logic [63:0]         best_d;
        vec_t                best_pt;
        vec_t                best_tan;
        vec_t                best_circ;
        logic                best_hc;
        logic [63:0]         s_acc;
        logic [63:0]         sq_n;
        logic [63:0]         sq_r;
        logic [63:0]         sq_b;
        logic [NUM_W-1:0]    num;
        logic [31:0]         rem;
        logic [T_W-1:0]      quo;
        vec_t                dir;
    } dp_t;

    typedef struct packed {
        logic found;
        vec_t pt;
        vec_t dir;
        vec_t circ;
        logic hc;
    } res_t;

    function automatic word_t sat32(input logic [32:0] v);
        if (v[32] != v[31])
        begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return word_t'(v[31:0]);
    endfunction

    function automatic word_t sdiff(input word_t a, input word_t b);
        return sat32({a[31], a} - {b[31], b});
    endfunction

endpackage

FILE: src/cpp_ram.sv
module cpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/closest_point_on_polyline.sv
// Load beat: written to vertex memory on accept, no result.
// Query beat: the result follows a pass over skipped vertices and segments (t uses the divider
// only when needed), then tangent normalization (only when a segment exists); with no vertices
// it follows at once. One shared 33x33 multiplier, the bit-serial divider, square root and
// direction divider do this work. Next beat is taken in the cycle after the result register loads.
// Reset (rst_n, async low): control idle, vertex_count 0; vertex memory not cleared.
module closest_point_on_polyline (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [11:0]                   vertex_index,
    input  cpp_pkg::word_t                x,
    input  cpp_pkg::word_t                y,
    input  cpp_pkg::word_t                z,
    input  cpp_pkg::word_t                tangent_x,
    input  cpp_pkg::word_t                tangent_y,
    input  cpp_pkg::word_t                tangent_z,
    input  cpp_pkg::word_t                center_x,
    input  cpp_pkg::word_t                center_y,
    input  cpp_pkg::word_t                center_z,
    input  logic                          starts_curve,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output cpp_pkg::word_t                point_x,
    output cpp_pkg::word_t                point_y,
    output cpp_pkg::word_t                point_z,
    output cpp_pkg::word_t                dir_x,
    output cpp_pkg::word_t                dir_y,
    output cpp_pkg::word_t                dir_z,
    output cpp_pkg::word_t                circ_x,
    output cpp_pkg::word_t                circ_y,
    output cpp_pkg::word_t                circ_z,
    output logic                          has_center,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpp_pkg::CNT_W-1:0]     cfg_data
);

    import cpp_pkg::*;

    state_t             state_reg, state_next;
    dp_t                dp_reg, dp_next;
    res_t               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   vcount_reg;

    mop_t               mul_op, tag_op_reg;
    logic [1:0]         mul_idx, tag_idx_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    vertex_t            ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [VTX_W-1:0]   ram_rd_bits;
    vertex_t            rd_row;

    logic [N_W-1:0]     n_cfg;
    logic [N_W-1:0]     i_inc;
    logic               more;
    logic               is_query;
    logic               fin_load;

    assign rd_row   = vertex_t'(ram_rd_bits);
    assign n_cfg    = (32'(vcount_reg) > 32'(MAX_VERTICES)) ? N_W'(MAX_VERTICES)
                                                             : N_W'(vcount_reg);
    assign i_inc    = dp_reg.i + N_W'(1);
    assign more     = i_inc < dp_reg.n;
    assign is_query = in_valid && (kind == KIND_QUERY);
    assign fin_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    cpp_ram #(
        .WIDTH(VTX_W),
        .DEPTH(MAX_VERTICES)
    ) u_vtx_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_bits)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (is_query) state_next = (n_cfg == '0) ? ST_FIN : ST_FIRST;
            ST_FIRST:  state_next = (dp_reg.n == N_W'(1)) ? ST_NORM : ST_SEG;
            ST_SEG:
            begin
                if (!rd_row.starts)
                begin
                    state_next = ST_DIFF;
                end
                else if (!more)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_DIFF:   state_next = ST_MLD;
            ST_MLD:    if (dp_reg.k == 6'd5) state_next = ST_MLD_W;
            ST_MLD_W:  state_next = ST_TDEC;
            ST_TDEC:
            begin
                if (dp_reg.len_acc > EPS_SQ && dp_reg.dot_acc > 66'sd0 &&
                    dp_reg.dot_acc < $signed({2'b00, dp_reg.len_acc}))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_MLP;
                end
            end
            ST_DIV:    if (dp_reg.k == 6'(FRAC_BITS - 1)) state_next = ST_MLP;
            ST_MLP:    if (dp_reg.k == 6'd5) state_next = ST_MLP_W;
            ST_MLP_W:  state_next = ST_EDIFF;
            ST_EDIFF:  state_next = ST_MDST;
            ST_MDST:   if (dp_reg.k == 6'd2) state_next = ST_MDST_W;
            ST_MDST_W: state_next = ST_CMP;
            ST_CMP:    state_next = more ? ST_SEG : ST_NORM;
            ST_NORM:   state_next = dp_reg.have ? ST_MNRM : ST_FIN;
            ST_MNRM:   if (dp_reg.k == 6'd2) state_next = ST_MNRM_W;
            ST_MNRM_W: state_next = ST_SQ0;
            ST_SQ0:    state_next = ST_SQRT;
            ST_SQRT:   if (dp_reg.k == 6'd31) state_next = ST_DCHK;
            ST_DCHK:   state_next = (dp_reg.sq_r[31:0] == 32'd0) ? ST_FIN : ST_DINIT;
            ST_DINIT:  state_next = ST_DDIV;
            ST_DDIV:
            begin
                if (dp_reg.k == 6'(NUM_W - 1))
                begin
                    state_next = (dp_reg.j == 2'd2) ? ST_FIN : ST_DINIT;
                end
            end
            ST_FIN:    if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        cfg_ready   = 1'b1;
        ram_wr_en   = (state_reg == ST_IDLE) && in_valid && (kind == KIND_LOAD) &&
                      (32'(vertex_index) < 32'(MAX_VERTICES));
        ram_wr_addr = ADDR_W'(vertex_index);
        ram_wr_data = '{starts: starts_curve,
                        cen: '{center_z, center_y, center_x},
                        tan: '{tangent_z, tangent_y, tangent_x},
                        pos: '{z, y, x}};
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(i_inc);
        mul_op      = M_NONE;
        mul_idx     = 2'(dp_reg.k);
        mul_a       = '0;
        mul_b       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_rd_en   = is_query && (n_cfg != '0);
                ram_rd_addr = '0;
            end
            ST_FIRST:
            begin
                ram_rd_en   = (dp_reg.n != N_W'(1));
                ram_rd_addr = ADDR_W'(1);
            end
            ST_SEG:    ram_rd_en = rd_row.starts && more;
            ST_CMP:    ram_rd_en = more;
            ST_MLD:
            begin
                if (dp_reg.k < 6'd3)
                begin
                    mul_op = M_LEN;
                    mul_a  = $signed({dp_reg.ab[mul_idx][31], dp_reg.ab[mul_idx]});
                    mul_b  = mul_a;
                end
                else
                begin
                    mul_op  = M_DOT;
                    mul_idx = 2'(dp_reg.k - 6'd3);
                    mul_a   = $signed({dp_reg.ab[mul_idx][31], dp_reg.ab[mul_idx]});
                    mul_b   = $signed({dp_reg.ap[mul_idx][31], dp_reg.ap[mul_idx]});
                end
            end
            ST_MLP:
            begin
                mul_b = $signed(33'(dp_reg.t));
                if (dp_reg.k < 6'd3)
                begin
                    mul_op = M_LP;
                    mul_a  = $signed({dp_reg.ab[mul_idx][31], dp_reg.ab[mul_idx]});
                end
                else
                begin
                    mul_op  = M_LT;
                    mul_idx = 2'(dp_reg.k - 6'd3);
                    mul_a   = $signed({dp_reg.dt[mul_idx][31], dp_reg.dt[mul_idx]});
                end
            end
            ST_MDST:
            begin
                mul_op = M_DST;
                mul_a  = $signed({dp_reg.e[mul_idx][31], dp_reg.e[mul_idx]});
                mul_b  = mul_a;
            end
            ST_MNRM:
            begin
                mul_op = M_NRM;
                mul_a  = $signed({dp_reg.best_tan[mul_idx][31], dp_reg.best_tan[mul_idx]});
                mul_b  = mul_a;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        logic [64:0]        two_r;
        logic [64:0]        sq_sum;
        logic [63:0]        r_shr;
        logic [32:0]        rem2;
        logic               ge;
        logic [T_W-1:0]     qfin;
        logic [31:0]        tmag;
        logic signed [65:0] psh;
        vec_t               cc;
        logic               hc;

        dp_next = dp_reg;
        two_r   = {dp_reg.r, 1'b0};
        sq_sum  = {1'b0, dp_reg.sq_r} + {1'b0, dp_reg.sq_b};
        r_shr   = dp_reg.sq_r >> 1;
        rem2    = {dp_reg.rem, dp_reg.num[NUM_W-1]};
        ge      = rem2 >= {1'b0, dp_reg.sq_r[31:0]};
        qfin    = {dp_reg.quo[T_W-2:0], ge};
        tmag    = dp_reg.best_tan[dp_reg.j][31] ? 32'(-dp_reg.best_tan[dp_reg.j])
                                                 : 32'(dp_reg.best_tan[dp_reg.j]);
        psh     = prod_reg >>> FRAC_BITS;
        cc      = (dp_reg.t < HALF_T) ? dp_reg.a.cen : dp_reg.b.cen;
        hc      = (32'(cc[0]) != NO_CENTER);

        case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                begin
                    dp_next.p         = '{z, y, x};
                    dp_next.n         = n_cfg;
                    dp_next.i         = '0;
                    dp_next.found     = (n_cfg != '0);
                    dp_next.have      = 1'b0;
                    dp_next.best_pt   = '0;
                    dp_next.best_tan  = '0;
                    dp_next.best_circ = '0;
                    dp_next.best_hc   = 1'b0;
                    dp_next.dir       = '0;
                end
            end
            ST_FIRST:
            begin
                dp_next.a = rd_row;
                dp_next.i = N_W'(1);
            end
            ST_SEG:
            begin
                if (rd_row.starts)
                begin
                    dp_next.a = rd_row;
                    if (more)
                    begin
                        dp_next.i = i_inc;
                    end
                end
                else
                begin
                    dp_next.b = rd_row;
                end
            end
            ST_DIFF:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dp_next.ab[c] = sdiff(dp_reg.b.pos[c], dp_reg.a.pos[c]);
                    dp_next.ap[c] = sdiff(dp_reg.p[c], dp_reg.a.pos[c]);
                    dp_next.dt[c] = sdiff(dp_reg.b.tan[c], dp_reg.a.tan[c]);
                end
                dp_next.len_acc = '0;
                dp_next.dot_acc = '0;
            end
            ST_MLD, ST_MLP, ST_MDST, ST_MNRM:
            begin
                dp_next.k = (state_next != state_reg) ? 6'd0 : dp_reg.k + 6'd1;
            end
            ST_TDEC:
            begin
                dp_next.t = '0;
                dp_next.r = dp_reg.dot_acc[63:0];
                if (dp_reg.len_acc > EPS_SQ && dp_reg.dot_acc > 66'sd0 &&
                    dp_reg.dot_acc >= $signed({2'b00, dp_reg.len_acc}))
                begin
                    dp_next.t = ONE_T;
                end
            end
            ST_DIV:
            begin
                if (two_r >= {1'b0, dp_reg.len_acc})
                begin
                    dp_next.r = 64'(two_r - {1'b0, dp_reg.len_acc});
                    dp_next.t = {dp_reg.t[T_W-2:0], 1'b1};
                end
                else
                begin
                    dp_next.r = two_r[63:0];
                    dp_next.t = {dp_reg.t[T_W-2:0], 1'b0};
                end
                dp_next.k = (state_next != state_reg) ? 6'd0 : dp_reg.k + 6'd1;
            end
            ST_EDIFF:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dp_next.e[c] = sdiff(dp_reg.p[c], dp_reg.q[c]);
                end
                dp_next.dist_acc = '0;
            end
            ST_CMP:
            begin
                if (!dp_reg.have || dp_reg.dist_acc < dp_reg.best_d)
                begin
                    dp_next.have      = 1'b1;
                    dp_next.best_d    = dp_reg.dist_acc;
                    dp_next.best_pt   = dp_reg.q;
                    dp_next.best_tan  = dp_reg.tl;
                    dp_next.best_hc   = hc;
                    dp_next.best_circ = hc ? cc : '0;
                end
                dp_next.a = dp_reg.b;
                if (more)
                begin
                    dp_next.i = i_inc;
                end
            end
            ST_NORM:   dp_next.s_acc = '0;
            ST_SQ0:
            begin
                dp_next.sq_n = dp_reg.s_acc;
                dp_next.sq_r = '0;
                dp_next.sq_b = 64'd1 << 62;
            end
            ST_SQRT:
            begin
                if ({1'b0, dp_reg.sq_n} >= sq_sum)
                begin
                    dp_next.sq_n = dp_reg.sq_n - sq_sum[63:0];
                    dp_next.sq_r = r_shr + dp_reg.sq_b;
                end
                else
                begin
                    dp_next.sq_r = r_shr;
                end
                dp_next.sq_b = dp_reg.sq_b >> 2;
                dp_next.k    = (state_next != state_reg) ? 6'd0 : dp_reg.k + 6'd1;
            end
            ST_DCHK:   dp_next.j = 2'd0;
            ST_DINIT:
            begin
                dp_next.num = {tmag, FRAC_BITS'(0)};
                dp_next.rem = '0;
                dp_next.quo = '0;
            end
            ST_DDIV:
            begin
                dp_next.rem = ge ? 32'(rem2 - {1'b0, dp_reg.sq_r[31:0]}) : rem2[31:0];
                dp_next.num = dp_reg.num << 1;
                dp_next.quo = qfin;
                if (dp_reg.k == 6'(NUM_W - 1))
                begin
                    dp_next.k = 6'd0;
                    dp_next.dir[dp_reg.j] = dp_reg.best_tan[dp_reg.j][31] ? -word_t'(qfin)
                                                                         : word_t'(qfin);
                    if (dp_reg.j != 2'd2)
                    begin
                        dp_next.j = dp_reg.j + 2'd1;
                    end
                end
                else
                begin
                    dp_next.k = dp_reg.k + 6'd1;
                end
            end
            default: ;
        endcase

        // multiplier results land in the cycle after issue
        case (tag_op_reg)
            M_LEN: dp_next.len_acc  = dp_reg.len_acc + prod_reg[63:0];
            M_DOT: dp_next.dot_acc  = dp_reg.dot_acc + prod_reg;
            M_LP:  dp_next.q[tag_idx_reg]  = dp_reg.a.pos[tag_idx_reg] + word_t'(psh[31:0]);
            M_LT:  dp_next.tl[tag_idx_reg] = dp_reg.a.tan[tag_idx_reg] + word_t'(psh[31:0]);
            M_DST: dp_next.dist_acc = dp_reg.dist_acc + prod_reg[63:0];
            M_NRM: dp_next.s_acc    = dp_reg.s_acc + prod_reg[63:0];
            default: ;
        endcase
    end

    // result register
    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (fin_load)
        begin
            res_next = '{found: dp_reg.found, pt: dp_reg.best_pt, dir: dp_reg.dir,
                         circ: dp_reg.best_circ, hc: dp_reg.best_hc};
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dp_reg        <= '0;
            out_valid_reg <= 1'b0;
            vcount_reg    <= '0;
            tag_op_reg    <= M_NONE;
            tag_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dp_reg        <= dp_next;
            out_valid_reg <= out_valid_next;
            tag_op_reg    <= mul_op;
            tag_idx_reg   <= mul_idx;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        res_reg  <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign found      = res_reg.found;
    assign point_x    = res_reg.pt[0];
    assign point_y    = res_reg.pt[1];
    assign point_z    = res_reg.pt[2];
    assign dir_x      = res_reg.dir[0];
    assign dir_y      = res_reg.dir[1];
    assign dir_z      = res_reg.dir[2];
    assign circ_x     = res_reg.circ[0];
    assign circ_y     = res_reg.circ[1];
    assign circ_z     = res_reg.circ[2];
    assign has_center = res_reg.hc;

`ifndef NO_ASSERTIONS
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MLP) |-> (dp_reg.t <= ONE_T))
        else $error("t above one during interpolation");

    a_seg_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG) |-> (dp_reg.i != '0 && dp_reg.i < dp_reg.n))
        else $error("segment index out of range");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after finish");

    a_have_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM && dp_reg.have) |-> dp_reg.found)
        else $error("segment winner without vertices");
`endif

endmodule
